/* rtl/core/assert_macros.svh */
// shared concurrent assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/core/rbdc_pkg.sv */
package rbdc_pkg;

    localparam logic MODE_DECODE = 1'b0;
    localparam logic MODE_ENCODE = 1'b1;

    localparam logic [7:0] STOP_MASK  = 8'h7F;
    localparam logic [7:0] WDAY_MASK  = 8'h07;

    localparam logic [31:0] SECS_PER_MIN  = 32'd60;
    localparam logic [31:0] SECS_PER_HOUR = 32'd3600;
    localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
    localparam logic [31:0] DAYS_PER_YEAR = 32'd365;
    localparam logic [31:0] SECS_PER_YEAR = DAYS_PER_YEAR * SECS_PER_DAY;

    localparam logic [7:0] SEC_MAX   = 8'd59;
    localparam logic [7:0] MIN_MAX   = 8'd59;
    localparam logic [7:0] HOUR_MAX  = 8'd23;
    localparam logic [7:0] WDAY_MIN  = 8'd1;
    localparam logic [7:0] WDAY_MAX  = 8'd7;
    localparam logic [7:0] DAY_MIN   = 8'd1;
    localparam logic [7:0] DAY_MAX   = 8'd31;
    localparam logic [7:0] MONTH_MIN = 8'd1;
    localparam logic [7:0] MONTH_MAX = 8'd12;
    localparam logic [7:0] YEAR_MIN  = 8'd1;
    localparam logic [7:0] YEAR_MAX  = 8'd99;
    localparam logic [7:0] FEB       = 8'd2;

    typedef struct packed {
        logic       mode;
        logic [7:0] sec_in;
        logic [7:0] min_in;
        logic [7:0] hour_in;
        logic [7:0] weekday_in;
        logic [7:0] day_in;
        logic [7:0] month_in;
        logic [7:0] year_in;
    } item_t;

    typedef struct packed {
        logic [31:0] epoch_seconds;
        logic [7:0]  sec_out;
        logic [7:0]  min_out;
        logic [7:0]  hour_out;
        logic [2:0]  weekday_out;
        logic [7:0]  day_out;
        logic [7:0]  month_out;
        logic [7:0]  year_out;
        logic        month_error;
    } result_t;

    // high nibble times ten plus low nibble, no digit check
    function automatic logic [7:0] from_bcd(input logic [7:0] b);
        return ({4'd0, b[7:4]} * 8'd10) + {4'd0, b[3:0]};
    endfunction

    // divide by ten through reciprocal, exact for values below 100
    function automatic logic [7:0] to_bcd(input logic [7:0] v,
                                          input logic [7:0] lo,
                                          input logic [7:0] hi);
        logic [15:0] prod;
        logic [3:0]  q;
        logic [7:0]  tens;
        logic [7:0]  rem;
        prod = {8'd0, v} * 16'd205;
        q    = prod[14:11];
        tens = {4'd0, q} * 8'd10;
        rem  = v - tens;
        if (v < lo || v > hi)
            return 8'd0;
        return {q, rem[3:0]};
    endfunction

    function automatic logic [8:0] days_before_month(input logic [3:0] idx);
        logic [8:0] d;
        unique case (idx)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

/* rtl/core/rbdc_item_if.sv */
interface rbdc_item_if;
    import rbdc_pkg::*;

    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/rbdc_result_if.sv */
interface rbdc_result_if;
    import rbdc_pkg::*;

    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/rtc_bcd_datetime_convert_unit.sv */
// Converts the seven date and time bytes of a BCD real-time clock. Mode 0 decodes the
// raw bytes (stop bit and weekday masked) into binary fields plus seconds since
// midnight at the start of year 0, flagging a month outside 1 to 12; mode 1 range-checks
// binary fields and returns BCD bytes, 0 where out of range. Every beat gives exactly
// one result beat, passed through an input register and a result register to the
// result side. One beat is taken in every cycle while the result side keeps up.
`include "assert_macros.svh"

module rtc_bcd_datetime_convert_unit (
    input  logic           clk,
    input  logic           rst_n,
    rbdc_item_if.sink      item,
    rbdc_result_if.source  result
);
    import rbdc_pkg::*;

    logic    in_valid_reg;
    item_t   in_data_reg;
    logic    out_valid_reg;
    result_t out_data_reg;

    logic    out_free;
    logic    advance;
    result_t res_next;

    logic [7:0]  sec_b, min_b, hour_b, day_b, month_b, year_b;
    logic        bad_month;
    logic        leap_add;
    logic [3:0]  month_idx;
    logic [8:0]  month_days;
    logic [8:0]  year_plus;
    logic [31:0] day_part;
    logic [31:0] secs;

    assign out_free   = !out_valid_reg || result.ready;
    assign advance    = in_valid_reg && out_free;
    assign item.ready = !in_valid_reg || out_free;

    always_comb
    begin
        sec_b      = from_bcd(in_data_reg.sec_in & STOP_MASK);
        min_b      = from_bcd(in_data_reg.min_in);
        hour_b     = from_bcd(in_data_reg.hour_in);
        day_b      = from_bcd(in_data_reg.day_in);
        month_b    = from_bcd(in_data_reg.month_in);
        year_b     = from_bcd(in_data_reg.year_in);
        bad_month  = (month_b < MONTH_MIN) || (month_b > MONTH_MAX);
        month_idx  = 4'(month_b - 8'd1);
        month_days = bad_month ? 9'd0 : days_before_month(month_idx);
        leap_add   = !bad_month && (year_b[1:0] == 2'd0) && (month_b > FEB);
        year_plus  = ({1'b0, year_b} + 9'd3) >> 2;
        day_part   = 32'(day_b) + 32'(month_days) + 32'(leap_add) + 32'(year_plus);
        // day - 1 folded into the constant term, wraps modulo 2^32
        secs       = day_part * SECS_PER_DAY + 32'(year_b) * SECS_PER_YEAR
                   - SECS_PER_DAY + 32'(sec_b) + 32'(min_b) * SECS_PER_MIN
                   + 32'(hour_b) * SECS_PER_HOUR;

        if (in_data_reg.mode == MODE_ENCODE)
        begin
            res_next.epoch_seconds = 32'd0;
            res_next.sec_out       = to_bcd(in_data_reg.sec_in, 8'd0, SEC_MAX);
            res_next.min_out       = to_bcd(in_data_reg.min_in, 8'd0, MIN_MAX);
            res_next.hour_out      = to_bcd(in_data_reg.hour_in, 8'd0, HOUR_MAX);
            res_next.weekday_out   = (in_data_reg.weekday_in < WDAY_MIN ||
                                      in_data_reg.weekday_in > WDAY_MAX)
                                   ? 3'd0 : in_data_reg.weekday_in[2:0];
            res_next.day_out       = to_bcd(in_data_reg.day_in, DAY_MIN, DAY_MAX);
            res_next.month_out     = to_bcd(in_data_reg.month_in, MONTH_MIN, MONTH_MAX);
            res_next.year_out      = to_bcd(in_data_reg.year_in, YEAR_MIN, YEAR_MAX);
            res_next.month_error   = 1'b0;
        end
        else
        begin
            res_next.epoch_seconds = secs;
            res_next.sec_out       = sec_b;
            res_next.min_out       = min_b;
            res_next.hour_out      = hour_b;
            res_next.weekday_out   = 3'(in_data_reg.weekday_in & WDAY_MASK);
            res_next.day_out       = day_b;
            res_next.month_out     = month_b;
            res_next.year_out      = year_b;
            res_next.month_error   = bad_month;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (item.ready)
                in_valid_reg <= item.valid;
            if (out_free)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
            in_data_reg <= item.data;
        if (advance)
            out_data_reg <= res_next;
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    `ASSERT_IMP(a_no_overrun, clk, rst_n, in_valid_reg && !out_free, !item.ready)
    `ASSERT_NXT(a_advance_shows, clk, rst_n, advance, result.valid)
    `ASSERT_IMP(a_err_month, clk, rst_n, result.valid && result.data.month_error,
                result.data.month_out == 8'd0 || result.data.month_out > MONTH_MAX)
    `ASSERT_IMP(a_encode_clean, clk, rst_n,
                advance && in_data_reg.mode == MODE_ENCODE,
                res_next.epoch_seconds == 32'd0 && !res_next.month_error)

endmodule

/* test/rtc_bcd_datetime_convert_unit_checker.sv */
module rtc_bcd_datetime_convert_unit_checker (
    input  logic   clk,
    input  logic   rst_n,
    rbdc_item_if   item,
    rbdc_result_if result,
    output int     fail_count,
    output int     pending_beats
);
    import rbdc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic [31:0] days_to_month [0:11] =
        '{32'd0, 32'd31, 32'd59, 32'd90, 32'd120, 32'd151,
          32'd181, 32'd212, 32'd243, 32'd273, 32'd304, 32'd334};

    result_t expected_datetimes[$];

    function automatic logic [31:0] bcd_value(input logic [7:0] b);
        return 32'(b[7:4]) * 32'd10 + 32'(b[3:0]);
    endfunction

    function automatic logic [7:0] bcd_byte(input logic [7:0] v, input logic [7:0] lo,
                                            input logic [7:0] hi);
        if (v < lo || v > hi)
            return 8'd0;
        return {4'(v / 8'd10), 4'(v % 8'd10)};
    endfunction

    function automatic result_t predict_datetime(input item_t it);
        result_t     r;
        logic [31:0] sec;
        logic [31:0] min;
        logic [31:0] hour;
        logic [31:0] day;
        logic [31:0] month;
        logic [31:0] year;
        logic [31:0] days;
        r = '0;
        if (it.mode == MODE_DECODE)
        begin
            sec   = bcd_value(it.sec_in & STOP_MASK);
            min   = bcd_value(it.min_in);
            hour  = bcd_value(it.hour_in);
            day   = bcd_value(it.day_in);
            month = bcd_value(it.month_in);
            year  = bcd_value(it.year_in);
            days  = day - 32'd1 + year * DAYS_PER_YEAR + (year + 32'd3) / 32'd4;
            if (month >= 32'(MONTH_MIN) && month <= 32'(MONTH_MAX))
            begin
                days = days + days_to_month[month - 32'd1];
                // leap day once february is past
                if (year % 32'd4 == 32'd0 && month > 32'(FEB))
                    days = days + 32'd1;
            end
            else
            begin
                r.month_error = 1'b1;
            end
            r.epoch_seconds = sec + min * SECS_PER_MIN + hour * SECS_PER_HOUR
                            + days * SECS_PER_DAY;
            r.sec_out     = sec[7:0];
            r.min_out     = min[7:0];
            r.hour_out    = hour[7:0];
            r.weekday_out = it.weekday_in[2:0];
            r.day_out     = day[7:0];
            r.month_out   = month[7:0];
            r.year_out    = year[7:0];
        end
        else
        begin
            r.sec_out   = bcd_byte(it.sec_in, 8'd0, SEC_MAX);
            r.min_out   = bcd_byte(it.min_in, 8'd0, MIN_MAX);
            r.hour_out  = bcd_byte(it.hour_in, 8'd0, HOUR_MAX);
            r.day_out   = bcd_byte(it.day_in, DAY_MIN, DAY_MAX);
            r.month_out = bcd_byte(it.month_in, MONTH_MIN, MONTH_MAX);
            r.year_out  = bcd_byte(it.year_in, YEAR_MIN, YEAR_MAX);
            if (it.weekday_in >= WDAY_MIN && it.weekday_in <= WDAY_MAX)
                r.weekday_out = it.weekday_in[2:0];
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns: %s", $realtime, what);
        fail_count++;
    endtask

    task automatic compare_field(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", field, got, want));
    endtask

    initial
    begin
        fail_count    = 0;
        pending_beats = 0;
    end

    always @(posedge clk)
    begin
        result_t want;
        result_t got;
        if (rst_n)
        begin
            if (item.valid && item.ready)
                expected_datetimes.push_back(predict_datetime(item.data));
            if (result.valid && result.ready)
            begin
                got = result.data;
                if (expected_datetimes.size() == 0)
                begin
                    report_mismatch("result beat with nothing expected");
                end
                else
                begin
                    want = expected_datetimes.pop_front();
                    compare_field("epoch_seconds", got.epoch_seconds, want.epoch_seconds);
                    compare_field("sec_out", 32'(got.sec_out), 32'(want.sec_out));
                    compare_field("min_out", 32'(got.min_out), 32'(want.min_out));
                    compare_field("hour_out", 32'(got.hour_out), 32'(want.hour_out));
                    compare_field("weekday_out", 32'(got.weekday_out),
                                  32'(want.weekday_out));
                    compare_field("day_out", 32'(got.day_out), 32'(want.day_out));
                    compare_field("month_out", 32'(got.month_out), 32'(want.month_out));
                    compare_field("year_out", 32'(got.year_out), 32'(want.year_out));
                    compare_field("month_error", 32'(got.month_error),
                                  32'(want.month_error));
                end
            end
            pending_beats = expected_datetimes.size();
        end
    end

endmodule

/* test/rtc_bcd_datetime_convert_unit_tb.sv */
module rtc_bcd_datetime_convert_unit_tb;
    import rbdc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASE_BEATS    = 150;
    localparam int HOLD_CYCLES    = 60;
    localparam int PRESSURE_BEATS = 30;
    localparam int DRAIN_CYCLES   = 8;
    localparam int STALL_LIMIT    = 5000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_beats;
    int   sender_idle_pct;
    int   sink_stall_pct;
    int   quiet_cycles;
    bit   hold_req;
    int   held;

    int   sender_pcts [0:4] = '{0, 82, 0, 11, 0};
    int   sink_pcts   [0:4] = '{0, 0, 82, 11, 0};

    rbdc_item_if   item_ch();
    rbdc_result_if result_ch();

    rtc_bcd_datetime_convert_unit DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    rtc_bcd_datetime_convert_unit_checker checker_inst (
        .clk           (clk),
        .rst_n         (rst_n),
        .item          (item_ch),
        .result        (result_ch),
        .fail_count    (fail_count),
        .pending_beats (pending_beats)
    );

    initial
        clk = 1'b0;

    always #2 clk = ~clk;

    function automatic item_t make_item(input logic mode, input logic [7:0] s,
                                        input logic [7:0] mi, input logic [7:0] h,
                                        input logic [7:0] w, input logic [7:0] d,
                                        input logic [7:0] mo, input logic [7:0] y);
        item_t it;
        it.mode       = mode;
        it.sec_in     = s;
        it.min_in     = mi;
        it.hour_in    = h;
        it.weekday_in = w;
        it.day_in     = d;
        it.month_in   = mo;
        it.year_in    = y;
        return it;
    endfunction

    function automatic logic [7:0] bcd_digits(input int unsigned v);
        return {4'(v / 10), 4'(v % 10)};
    endfunction

    function automatic item_t random_datetime();
        int unsigned pick;
        int unsigned top_val;
        logic        mode;
        pick = $urandom_range(99);
        mode = 1'($urandom_range(1));
        // raw noise on every byte
        if (pick < 30)
            return make_item(mode, 8'($urandom), 8'($urandom), 8'($urandom),
                             8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        if (mode == MODE_DECODE)
            return make_item(MODE_DECODE,
                             {1'($urandom_range(1)), 7'(bcd_digits($urandom_range(59)))},
                             bcd_digits($urandom_range(59)),
                             bcd_digits($urandom_range(23)),
                             8'($urandom),
                             bcd_digits($urandom_range(31, 1)),
                             bcd_digits($urandom_range(12, 1)),
                             bcd_digits($urandom_range(99)));
        // binary fields, sometimes past their legal range
        top_val = (pick < 45) ? 127 : 0;
        return make_item(MODE_ENCODE,
                         8'($urandom_range(top_val > 0 ? top_val : 59)),
                         8'($urandom_range(top_val > 0 ? top_val : 59)),
                         8'($urandom_range(top_val > 0 ? top_val : 23)),
                         8'($urandom_range(top_val > 0 ? 15 : 7, top_val > 0 ? 0 : 1)),
                         8'($urandom_range(top_val > 0 ? top_val : 31, top_val > 0 ? 0 : 1)),
                         8'($urandom_range(top_val > 0 ? 31 : 12, top_val > 0 ? 0 : 1)),
                         8'($urandom_range(top_val > 0 ? 255 : 99, top_val > 0 ? 0 : 1)));
    endfunction

    // called at a falling edge, returns at the falling edge after the beat is taken
    task automatic send_beat(input item_t it);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.data  <= it;
        do
            @(posedge clk);
        while (!item_ch.ready);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        while (pending_beats != 0)
            @(negedge clk);
    endtask

    // result side
    initial
    begin
        result_ch.ready = 1'b0;
        held = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                held = HOLD_CYCLES;
            end
            if (held > 0)
            begin
                held--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        item_ch.valid   = 1'b0;
        item_ch.data    = '0;
        sender_idle_pct = 0;
        sink_stall_pct  = 0;
        hold_req        = 1'b0;
        quiet_cycles    = 0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // decode corners: empty registers, epoch start, stop bit, bad digits, leap years
        send_beat(make_item(MODE_DECODE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_beat(make_item(MODE_DECODE, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h01, 8'h00));
        send_beat(make_item(MODE_DECODE, 8'hD9, 8'h59, 8'h23, 8'hFF, 8'h31, 8'h12, 8'h99));
        send_beat(make_item(MODE_DECODE, 8'h80, 8'h00, 8'h00, 8'hF8, 8'h01, 8'h01, 8'h01));
        send_beat(make_item(MODE_DECODE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_beat(make_item(MODE_DECODE, 8'h7F, 8'h9A, 8'h3F, 8'h07, 8'hAA, 8'h09, 8'hF0));
        send_beat(make_item(MODE_DECODE, 8'h00, 8'h00, 8'h00, 8'h02, 8'h29, 8'h02, 8'h04));
        send_beat(make_item(MODE_DECODE, 8'h00, 8'h00, 8'h00, 8'h03, 8'h01, 8'h03, 8'h04));
        send_beat(make_item(MODE_DECODE, 8'h00, 8'h00, 8'h00, 8'h03, 8'h01, 8'h03, 8'h05));
        send_beat(make_item(MODE_DECODE, 8'h30, 8'h15, 8'h12, 8'h05, 8'h15, 8'h13, 8'h10));
        send_beat(make_item(MODE_DECODE, 8'h30, 8'h15, 8'h12, 8'h05, 8'h15, 8'h00, 8'h08));
        send_beat(make_item(MODE_DECODE, 8'h00, 8'h00, 8'h00, 8'h06, 8'h00, 8'h01, 8'h00));
        send_beat(make_item(MODE_DECODE, 8'h59, 8'h59, 8'h23, 8'h04, 8'h31, 8'h12, 8'h03));
        // encode corners: lows, highs, just past, all ones
        send_beat(make_item(MODE_ENCODE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_beat(make_item(MODE_ENCODE, 8'd0, 8'd0, 8'd0, 8'd1, 8'd1, 8'd1, 8'd1));
        send_beat(make_item(MODE_ENCODE, 8'd59, 8'd59, 8'd23, 8'd7, 8'd31, 8'd12, 8'd99));
        send_beat(make_item(MODE_ENCODE, 8'd60, 8'd60, 8'd24, 8'd8, 8'd32, 8'd13, 8'd100));
        send_beat(make_item(MODE_ENCODE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_beat(make_item(MODE_ENCODE, 8'd45, 8'd38, 8'd19, 8'd3, 8'd27, 8'd10, 8'd50));
        send_beat(make_item(MODE_ENCODE, 8'h80, 8'h40, 8'h20, 8'h10, 8'h08, 8'h04, 8'h02));
        wait_drained();

        for (int phase = 0; phase < 5; phase++)
        begin
            sender_idle_pct = sender_pcts[phase];
            sink_stall_pct  = sink_pcts[phase];
            if (phase == 0)
            begin
                // back up the result side while beats keep coming
                hold_req = 1'b1;
                repeat (PRESSURE_BEATS) send_beat(random_datetime());
            end
            repeat (PHASE_BEATS) send_beat(random_datetime());
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending_beats == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/rbdc_pkg.sv
rtl/core/rbdc_item_if.sv
rtl/core/rbdc_result_if.sv
rtl/core/rtc_bcd_datetime_convert_unit.sv
test/rtc_bcd_datetime_convert_unit_checker.sv
test/rtc_bcd_datetime_convert_unit_tb.sv
